// File: sv/lps_pkg.sv
// lps_pkg: shared types and constants for the led pattern sequencer
// used by lps_step and led_pattern_sequencer_core, no dependencies
`default_nettype none

package lps_pkg;

    // pattern codes, shared by selected mode and running pattern
    localparam logic [1:0] PAT_IDLE  = 2'd0;
    localparam logic [1:0] PAT_CHASE = 2'd1;
    localparam logic [1:0] PAT_FILL  = 2'd2;
    localparam logic [1:0] PAT_BLINK = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_CHASE_DWELL   = 2'd0;
    localparam logic [1:0] CFG_BLINK_DWELL   = 2'd1;
    localparam logic [1:0] CFG_BURST_REPEATS = 2'd2;
    localparam logic [1:0] CFG_BLINK_CYCLES  = 2'd3;

    // register reset values
    localparam logic [15:0] CHASE_DWELL_RST   = 16'd200;
    localparam logic [15:0] BLINK_DWELL_RST   = 16'd500;
    localparam logic [3:0]  BURST_REPEATS_RST = 4'd4;
    localparam logic [7:0]  BLINK_CYCLES_RST  = 8'd8;

    // steps per pattern repeat
    localparam logic [4:0] CHASE_STEPS = 5'd15;
    localparam logic [4:0] FILL_STEPS  = 5'd8;
    localparam logic [4:0] BLINK_STEPS = 5'd2;

    // fill pattern: centre outward, then outside inward
    localparam logic [7:0] FILL_MASKS [8] = '{
        8'h18, 8'h3C, 8'h7E, 8'hFF, 8'h7E, 8'h3C, 8'h18, 8'h00
    };

    typedef struct packed {
        logic [15:0] chase_dwell;
        logic [15:0] blink_dwell;
        logic [3:0]  burst_repeats;
        logic [7:0]  blink_cycles;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode_select;
        logic [1:0]  active_pattern;
        logic [3:0]  phase;
        logic [7:0]  repeat_count;
        logic [15:0] dwell_count;
    } t_state;

    typedef struct packed {
        logic [7:0] leds;
        logic [1:0] selected_mode;
        logic [1:0] running_pattern;
        logic       burst_done;
    } t_result;

endpackage

`default_nettype wire

// File: sv/lps_in_if.sv
// lps_in_if: input channel carrying tick and press events
// valid/ready handshake, no dependencies
`default_nettype none

interface lps_in_if;
    logic valid;
    logic ready;
    logic tick;
    logic press;

    modport source (output valid, output tick, output press, input ready);
    modport sink   (input valid, input tick, input press, output ready);
endinterface

`default_nettype wire

// File: sv/lps_out_if.sv
// lps_out_if: result channel carrying led drive and status
// valid/ready handshake, no dependencies
`default_nettype none

interface lps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] leds;
    logic [1:0] selected_mode;
    logic [1:0] running_pattern;
    logic       burst_done;

    modport source (output valid, output leds, output selected_mode,
                    output running_pattern, output burst_done, input ready);
    modport sink   (input valid, input leds, input selected_mode,
                    input running_pattern, input burst_done, output ready);
endinterface

`default_nettype wire

// File: sv/led_pattern_sequencer_core.sv
// Eight-LED pattern sequencer. Every input transfer (a tick, a press, or both)
// yields exactly one result transfer carrying the led drive, the selected mode,
// the running pattern and a burst-done flag. The block takes one transfer per
// clock cycle unless the result channel stalls: all work for a transfer is done
// in a single pass of logic from the state registers into a result register,
// so a result appears in the cycle after its input transfer. That single result
// register sets the throughput: a new input is taken whenever the register is
// empty or its result is being taken in the same cycle. Configuration writes
// are registered and are meant to be issued while no results are pending.
// depends on lps_pkg, lps_in_if, lps_out_if and lps_step
`default_nettype none

module led_pattern_sequencer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lps_in_if.sink           i_in,
    lps_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    lps_pkg::t_cfg    r_cfg;
    lps_pkg::t_state  r_state;
    lps_pkg::t_state  n_state;
    lps_pkg::t_result r_result;
    lps_pkg::t_result n_result;
    logic             r_out_valid;
    logic             in_xfer;

    // input is taken when the result register frees up
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    lps_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_tick   (i_in.tick),
        .i_press  (i_in.press),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chase_dwell   <= lps_pkg::CHASE_DWELL_RST;
            r_cfg.blink_dwell   <= lps_pkg::BLINK_DWELL_RST;
            r_cfg.burst_repeats <= lps_pkg::BURST_REPEATS_RST;
            r_cfg.blink_cycles  <= lps_pkg::BLINK_CYCLES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lps_pkg::CFG_CHASE_DWELL:   r_cfg.chase_dwell   <= i_cfg_data;
                lps_pkg::CFG_BLINK_DWELL:   r_cfg.blink_dwell   <= i_cfg_data;
                lps_pkg::CFG_BURST_REPEATS: r_cfg.burst_repeats <= i_cfg_data[3:0];
                lps_pkg::CFG_BLINK_CYCLES:  r_cfg.blink_cycles  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.leds            = r_result.leds;
    assign o_out.selected_mode   = r_result.selected_mode;
    assign o_out.running_pattern = r_result.running_pattern;
    assign o_out.burst_done      = r_result.burst_done;

endmodule

`default_nettype wire

// File: sv/lps_step.sv
// lps_step: next-state and led mask logic for one transfer
// depends on lps_pkg types and constants
`default_nettype none

module lps_step (
    input  var lps_pkg::t_state  i_state,
    input  var lps_pkg::t_cfg    i_cfg,
    input  wire logic            i_tick,
    input  wire logic            i_press,
    output var lps_pkg::t_state  o_state,
    output var lps_pkg::t_result o_result
);

    always_comb begin
        lps_pkg::t_state n_st;
        logic [15:0] dwell_lim;
        logic [7:0]  rep_lim;
        logic [4:0]  steps;
        logic [15:0] dwell_inc;
        logic [4:0]  phase_inc;
        logic [7:0]  rep_inc;
        logic        done;
        logic [2:0]  chase_led;
        logic [7:0]  mask;

        n_st = i_state;
        done = 1'b0;

        // a press advances the selected mode first
        if (i_press) begin
            n_st.mode_select = i_state.mode_select + 2'd1;
        end

        // limits of the running pattern, zero acts as one
        if (i_state.active_pattern == lps_pkg::PAT_BLINK) begin
            dwell_lim = (i_cfg.blink_dwell == 16'd0) ? 16'd1 : i_cfg.blink_dwell;
            rep_lim   = (i_cfg.blink_cycles == 8'd0) ? 8'd1 : i_cfg.blink_cycles;
            steps     = lps_pkg::BLINK_STEPS;
        end else begin
            dwell_lim = (i_cfg.chase_dwell == 16'd0) ? 16'd1 : i_cfg.chase_dwell;
            rep_lim   = (i_cfg.burst_repeats == 4'd0) ? 8'd1
                                                      : {4'd0, i_cfg.burst_repeats};
            steps     = (i_state.active_pattern == lps_pkg::PAT_CHASE)
                        ? lps_pkg::CHASE_STEPS : lps_pkg::FILL_STEPS;
        end

        dwell_inc = i_state.dwell_count + 16'd1;
        phase_inc = {1'b0, i_state.phase} + 5'd1;
        rep_inc   = i_state.repeat_count + 8'd1;

        // tick advances dwell, then step, then repeat
        if (i_tick && i_state.active_pattern != lps_pkg::PAT_IDLE) begin
            if (dwell_inc != 16'd0 && dwell_inc < dwell_lim) begin
                n_st.dwell_count = dwell_inc;
            end else begin
                n_st.dwell_count = 16'd0;
                if (phase_inc < steps) begin
                    n_st.phase = phase_inc[3:0];
                end else begin
                    n_st.phase = 4'd0;
                    if (rep_inc != 8'd0 && rep_inc < rep_lim) begin
                        n_st.repeat_count = rep_inc;
                    end else begin
                        n_st.repeat_count   = 8'd0;
                        n_st.active_pattern = lps_pkg::PAT_IDLE;
                        done                = 1'b1;
                    end
                end
            end
        end

        // idle picks up the selected mode at once
        if (n_st.active_pattern == lps_pkg::PAT_IDLE &&
            n_st.mode_select != lps_pkg::PAT_IDLE) begin
            n_st.active_pattern = n_st.mode_select;
            n_st.phase          = 4'd0;
            n_st.repeat_count   = 8'd0;
            n_st.dwell_count    = 16'd0;
        end

        // ping-pong led position: up 0..7, back down 6..0
        if (n_st.phase < 4'd8) begin
            chase_led = n_st.phase[2:0];
        end else if (n_st.phase <= 4'd14) begin
            chase_led = 3'(4'd14 - n_st.phase);
        end else begin
            chase_led = 3'd0;
        end

        // led mask of the pattern now shown
        case (n_st.active_pattern)
            lps_pkg::PAT_CHASE: mask = 8'd1 << chase_led;
            lps_pkg::PAT_FILL:  mask = lps_pkg::FILL_MASKS[n_st.phase[2:0]];
            lps_pkg::PAT_BLINK: mask = (n_st.phase == 4'd0) ? 8'hFF : 8'h00;
            default:            mask = 8'h00;
        endcase

        o_state                  = n_st;
        o_result.leds            = mask;
        o_result.selected_mode   = n_st.mode_select;
        o_result.running_pattern = n_st.active_pattern;
        o_result.burst_done      = done;
    end

endmodule

`default_nettype wire

// File: test/led_pattern_sequencer_core_tb.sv
// led_pattern_sequencer_core_tb: self-checking bench for the led pattern sequencer core
// depends on lps_pkg, lps_in_if, lps_out_if and led_pattern_sequencer_core
`default_nettype none

module led_pattern_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // directed stimulus rows: an input transfer repeated count times, or a register write
    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              tick;
        logic              press;
        logic [4:0]        count;
        logic [1:0]        index;
        logic [15:0]       data;
        logic              typed;
        lps_pkg::t_result  want;
    } t_row;

    localparam int N_ROWS     = 20;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 100;
    localparam int N_FIXED    = 6;

    logic i_clk;
    logic i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    lps_in_if  in_if ();
    lps_out_if out_if ();

    led_pattern_sequencer_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // mirror of the sequencer registers and state
    logic [15:0] chase_dwell_r   = lps_pkg::CHASE_DWELL_RST;
    logic [15:0] blink_dwell_r   = lps_pkg::BLINK_DWELL_RST;
    logic [3:0]  burst_repeats_r = lps_pkg::BURST_REPEATS_RST;
    logic [7:0]  blink_cycles_r  = lps_pkg::BLINK_CYCLES_RST;

    logic [1:0]  sel_mode    = lps_pkg::PAT_IDLE;
    logic [1:0]  run_pat     = lps_pkg::PAT_IDLE;
    logic [4:0]  step_idx    = '0;
    logic [7:0]  reps_done   = '0;
    logic [15:0] dwell_ticks = '0;

    // fill masks: centre outward, then outside inward
    logic [7:0] fill_shape [8] = '{
        8'h18, 8'h3C, 8'h7E, 8'hFF, 8'h7E, 8'h3C, 8'h18, 8'h00
    };

    lps_pkg::t_result led_status_q [$];
    int      mismatch_count = 0;
    bit      idle_on        = 1'b1;
    bit      valid_held     = 1'b0;

    // register settings for the first random phases: minimum, zero, small, maximum, mixed
    int unsigned phase_regs [N_FIXED][4] = '{
        '{1, 1, 1, 1},
        '{0, 0, 0, 0},
        '{3, 2, 2, 3},
        '{65535, 65535, 15, 255},
        '{1, 1, 15, 255},
        '{2, 1, 1, 1}
    };

    t_row dir_rows [N_ROWS] = '{
        // idle after reset, tick while idle
        '{ROW_ITEM, 1'b0, 1'b0, 5'd1, '0, '0, 1'b1,
          '{8'h00, lps_pkg::PAT_IDLE, lps_pkg::PAT_IDLE, 1'b0}},
        '{ROW_ITEM, 1'b1, 1'b0, 5'd1, '0, '0, 1'b1,
          '{8'h00, lps_pkg::PAT_IDLE, lps_pkg::PAT_IDLE, 1'b0}},
        // press from idle starts the chase at once
        '{ROW_ITEM, 1'b0, 1'b1, 5'd1, '0, '0, 1'b1,
          '{8'h01, lps_pkg::PAT_CHASE, lps_pkg::PAT_CHASE, 1'b0}},
        '{ROW_ITEM, 1'b1, 1'b0, 5'd1, '0, '0, 1'b1,
          '{8'h01, lps_pkg::PAT_CHASE, lps_pkg::PAT_CHASE, 1'b0}},
        '{ROW_ITEM, 1'b1, 1'b1, 5'd1, '0, '0, 1'b1,
          '{8'h01, lps_pkg::PAT_FILL, lps_pkg::PAT_CHASE, 1'b0}},
        // zero values act as one
        '{ROW_CFG, 1'b0, 1'b0, 5'd0, lps_pkg::CFG_CHASE_DWELL, 16'd0, 1'b0, '0},
        '{ROW_CFG, 1'b0, 1'b0, 5'd0, lps_pkg::CFG_BURST_REPEATS, 16'd0, 1'b0, '0},
        '{ROW_CFG, 1'b0, 1'b0, 5'd0, lps_pkg::CFG_BLINK_DWELL, 16'd0, 1'b0, '0},
        '{ROW_CFG, 1'b0, 1'b0, 5'd0, lps_pkg::CFG_BLINK_CYCLES, 16'd0, 1'b0, '0},
        // lowered dwell ends the step on the next tick
        '{ROW_ITEM, 1'b1, 1'b0, 5'd1, '0, '0, 1'b1,
          '{8'h02, lps_pkg::PAT_FILL, lps_pkg::PAT_CHASE, 1'b0}},
        '{ROW_ITEM, 1'b1, 1'b0, 5'd13, '0, '0, 1'b0, '0},
        // chase ends and fill starts on the same transfer
        '{ROW_ITEM, 1'b1, 1'b0, 5'd1, '0, '0, 1'b1,
          '{8'h18, lps_pkg::PAT_FILL, lps_pkg::PAT_FILL, 1'b1}},
        '{ROW_ITEM, 1'b1, 1'b1, 5'd1, '0, '0, 1'b1,
          '{8'h3C, lps_pkg::PAT_BLINK, lps_pkg::PAT_FILL, 1'b0}},
        '{ROW_ITEM, 1'b1, 1'b0, 5'd6, '0, '0, 1'b0, '0},
        '{ROW_ITEM, 1'b1, 1'b0, 5'd1, '0, '0, 1'b1,
          '{8'hFF, lps_pkg::PAT_BLINK, lps_pkg::PAT_BLINK, 1'b1}},
        '{ROW_ITEM, 1'b1, 1'b1, 5'd1, '0, '0, 1'b1,
          '{8'h00, lps_pkg::PAT_IDLE, lps_pkg::PAT_BLINK, 1'b0}},
        '{ROW_ITEM, 1'b1, 1'b1, 5'd1, '0, '0, 1'b1,
          '{8'h01, lps_pkg::PAT_CHASE, lps_pkg::PAT_CHASE, 1'b1}},
        // presses wrap the selected mode while the chase keeps running
        '{ROW_ITEM, 1'b0, 1'b1, 5'd1, '0, '0, 1'b1,
          '{8'h01, lps_pkg::PAT_FILL, lps_pkg::PAT_CHASE, 1'b0}},
        '{ROW_ITEM, 1'b0, 1'b1, 5'd1, '0, '0, 1'b1,
          '{8'h01, lps_pkg::PAT_BLINK, lps_pkg::PAT_CHASE, 1'b0}},
        '{ROW_ITEM, 1'b0, 1'b1, 5'd1, '0, '0, 1'b1,
          '{8'h01, lps_pkg::PAT_IDLE, lps_pkg::PAT_CHASE, 1'b0}}
    };

    // clock
    initial i_clk = 1'b0;
    always #5ns i_clk = ~i_clk;

    // next led status for one transfer, advancing the mirrored state
    function automatic lps_pkg::t_result sequencer_step(input logic tick, input logic press);
        logic [15:0]      dwell_lim;
        logic [4:0]       n_steps;
        logic [7:0]       rep_lim;
        logic [3:0]       lit;
        lps_pkg::t_result res;
        res = '0;
        if (press)
            sel_mode = sel_mode + 2'd1;
        if (tick && run_pat != lps_pkg::PAT_IDLE) begin
            if (run_pat == lps_pkg::PAT_BLINK) begin
                dwell_lim = (blink_dwell_r == 0) ? 16'd1 : blink_dwell_r;
                n_steps   = lps_pkg::BLINK_STEPS;
                rep_lim   = (blink_cycles_r == 0) ? 8'd1 : blink_cycles_r;
            end else begin
                dwell_lim = (chase_dwell_r == 0) ? 16'd1 : chase_dwell_r;
                n_steps   = (run_pat == lps_pkg::PAT_CHASE)
                            ? lps_pkg::CHASE_STEPS : lps_pkg::FILL_STEPS;
                rep_lim   = (burst_repeats_r == 0) ? 8'd1 : {4'd0, burst_repeats_r};
            end
            // dwell and repeat counters wrap at their widths
            dwell_ticks = dwell_ticks + 16'd1;
            if (dwell_ticks >= dwell_lim || dwell_ticks == 0) begin
                dwell_ticks = '0;
                step_idx    = step_idx + 5'd1;
                if (step_idx >= n_steps) begin
                    step_idx  = '0;
                    reps_done = reps_done + 8'd1;
                    if (reps_done >= rep_lim || reps_done == 0) begin
                        reps_done      = '0;
                        run_pat        = lps_pkg::PAT_IDLE;
                        res.burst_done = 1'b1;
                    end
                end
            end
        end
        // an idle sequencer takes up the selected mode right away
        if (run_pat == lps_pkg::PAT_IDLE && sel_mode != lps_pkg::PAT_IDLE) begin
            run_pat     = sel_mode;
            step_idx    = '0;
            reps_done   = '0;
            dwell_ticks = '0;
        end
        case (run_pat)
            lps_pkg::PAT_CHASE: begin
                lit = (step_idx < 8) ? step_idx[3:0]
                    : (step_idx <= 14) ? 4'(14 - step_idx) : 4'd0;
                res.leds = 8'd1 << lit;
            end
            lps_pkg::PAT_FILL:  res.leds = fill_shape[step_idx[2:0]];
            lps_pkg::PAT_BLINK: res.leds = (step_idx == 0) ? 8'hFF : 8'h00;
            default:            res.leds = 8'h00;
        endcase
        res.selected_mode   = sel_mode;
        res.running_pattern = run_pat;
        return res;
    endfunction

    // one input transfer; the expectation is queued when it is accepted
    task automatic send_item(input logic tick, input logic press, input logic typed,
                             input lps_pkg::t_result want);
        lps_pkg::t_result predicted;
        in_if.valid <= 1'b1;
        in_if.tick  <= tick;
        in_if.press <= press;
        i_cfg_we    <= 1'b0;
        valid_held   = 1'b1;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1)
            @(posedge i_clk);
        predicted = sequencer_step(tick, press);
        led_status_q.push_back(typed ? want : predicted);
        // random source gap
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            valid_held   = 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        if (valid_held) begin
            in_if.valid <= 1'b0;
            valid_held   = 1'b0;
        end
        while (led_status_q.size() != 0)
            @(posedge i_clk);
    endtask

    // register write, mirrored into the predictor; the enable is lowered by send_item
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            lps_pkg::CFG_CHASE_DWELL:   chase_dwell_r   = data;
            lps_pkg::CFG_BLINK_DWELL:   blink_dwell_r   = data;
            lps_pkg::CFG_BURST_REPEATS: burst_repeats_r = data[3:0];
            lps_pkg::CFG_BLINK_CYCLES:  blink_cycles_r  = data[7:0];
            default: ;
        endcase
    endtask

    // result sink: random stalls and comparison against the oldest expectation
    initial begin
        int               stall_left;
        lps_pkg::t_result got;
        lps_pkg::t_result want;
        stall_left = 0;
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got = '{out_if.leds, out_if.selected_mode, out_if.running_pattern,
                        out_if.burst_done};
                if (led_status_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: leds %h mode %0d pat %0d done %b",
                                 got.leds, got.selected_mode, got.running_pattern,
                                 got.burst_done);
                end else begin
                    want = led_status_q.pop_front();
                    if (got.leds !== want.leds
                        || got.selected_mode !== want.selected_mode
                        || got.running_pattern !== want.running_pattern
                        || got.burst_done !== want.burst_done) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: leds %h/%h mode %0d/%0d pat %0d/%0d done %b/%b",
                                     want.leds, got.leds, want.selected_mode,
                                     got.selected_mode, want.running_pattern,
                                     got.running_pattern, want.burst_done, got.burst_done);
                    end
                end
            end
            if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left != 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        logic [15:0] regs [4];
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= lps_pkg::CFG_CHASE_DWELL;
        i_cfg_data  <= '0;
        in_if.valid <= 1'b0;
        in_if.tick  <= 1'b0;
        in_if.press <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_reg(dir_rows[r].index, dir_rows[r].data);
            else
                for (int k = 0; k < dir_rows[r].count; k++)
                    send_item(dir_rows[r].tick, dir_rows[r].press, dir_rows[r].typed,
                              dir_rows[r].want);
        end

        // random phases, each with its own register setting; the last one runs without gaps
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph < N_FIXED) begin
                for (int i = 0; i < 4; i++)
                    regs[i] = 16'(phase_regs[ph][i]);
            end else begin
                regs[0] = 16'($urandom_range(1, 5));
                regs[1] = 16'($urandom_range(1, 5));
                regs[2] = 16'($urandom_range(0, 3));
                regs[3] = 16'($urandom_range(0, 6));
            end
            write_reg(lps_pkg::CFG_CHASE_DWELL, regs[0]);
            write_reg(lps_pkg::CFG_BLINK_DWELL, regs[1]);
            write_reg(lps_pkg::CFG_BURST_REPEATS, regs[2]);
            write_reg(lps_pkg::CFG_BLINK_CYCLES, regs[3]);
            idle_on = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_LEN; k++)
                send_item($urandom_range(0, 7) != 0, $urandom_range(0, 11) == 0, 1'b0, '0);
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && led_status_q.size() == 0)
            $display("led_pattern_sequencer_core_tb OK");
        else
            $display("led_pattern_sequencer_core_tb NOT OK");
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("led_pattern_sequencer_core_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
